/* rtl/qpr_pkg.sv */
package qpr_pkg;

  localparam int FracBits = 14;
  localparam int OpaW     = 20;
  localparam int OpbW     = 17;
  localparam int ProdW    = OpaW + OpbW;
  localparam int SumW     = ProdW + 2;
  localparam int RndW     = SumW - FracBits;

  typedef logic signed [OpaW-1:0]  opa_t;
  typedef logic signed [OpbW-1:0]  opb_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [RndW-1:0]  rnd_t;

  typedef opa_t  opa4_t  [4];
  typedef opb_t  opb4_t  [4];
  typedef prod_t prod16_t [16];
  typedef rnd_t  rnd4_t  [4];

  localparam opb_t OneQ  = opb_t'(1 << FracBits);
  localparam sum_t Half  = sum_t'(1 << (FracBits - 1));
  localparam rnd_t SatHi = rnd_t'(32767);
  localparam rnd_t SatLo = rnd_t'(-32768);

  localparam logic ModeProduct = 1'b0;
  localparam logic ModeRotate  = 1'b1;

endpackage

/* rtl/quaternion_product_rotate.sv */
// channel  | handshake        | word
// ---------+------------------+------------------------------------------
// input    | start_i, busy_o  | mode_i, q_x_i..q_w_i, p_x_i..p_w_i
// result   | valid_o (strobe) | r_x_o, r_y_o, r_z_o, r_w_o, overflow_o
//
// One word accepted per cycle; each result passes through two multiply/round passes
// (16 multipliers each) and then a saturation register.
// busy_o stays low: the pipeline never stalls, and the receiver cannot hold results.
// Reset clears all stage valid bits; data registers are not reset.
module quaternion_product_rotate
  import qpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] p_x_i,
  input  logic signed [15:0] p_y_i,
  input  logic signed [15:0] p_z_i,
  input  logic signed [15:0] p_w_i,
  output logic               valid_o,
  output logic signed [15:0] r_x_o,
  output logic signed [15:0] r_y_o,
  output logic signed [15:0] r_z_o,
  output logic signed [15:0] r_w_o,
  output logic               overflow_o
);

  logic               acc;
  opa4_t              a1;
  opb4_t              b1;
  logic               v1, v2, v3, v4;
  prod16_t            pr1, pr3;
  rnd4_t              t2, rn4;
  opa4_t              a3;
  opb4_t              b3;
  logic signed [15:0] q1_q [4];
  logic signed [15:0] q2_q [4];
  logic               m1_q, m2_q, m3_q, m4_q;
  logic signed [15:0] res [4];

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  always_comb begin
    a1[0] = opa_t'(q_x_i);
    a1[1] = opa_t'(q_y_i);
    a1[2] = opa_t'(q_z_i);
    a1[3] = opa_t'(q_w_i);
    b1[0] = opb_t'(p_x_i);
    b1[1] = opb_t'(p_y_i);
    b1[2] = opb_t'(p_z_i);
    b1[3] = (mode_i == ModeRotate) ? '0 : opb_t'(p_w_i);
  end

  qpr_mul u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (acc),
    .a_i    (a1),
    .b_i    (b1),
    .vld_o  (v1),
    .prod_o (pr1)
  );

  qpr_rnd u_rnd_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v1),
    .prod_i (pr1),
    .vld_o  (v2),
    .rnd_o  (t2)
  );

  always_ff @(posedge clk_i) begin
    q1_q[0] <= q_x_i;
    q1_q[1] <= q_y_i;
    q1_q[2] <= q_z_i;
    q1_q[3] <= q_w_i;
    m1_q    <= mode_i;
    q2_q    <= q1_q;
    m2_q    <= m1_q;
    m3_q    <= m2_q;
    m4_q    <= m3_q;
  end

  // product mode: multiply by the unit scalar, so the second pass passes t through
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      a3[c] = t2[c][OpaW-1:0];
    end
    if (m2_q == ModeRotate) begin
      b3[0] = -opb_t'(q2_q[0]);
      b3[1] = -opb_t'(q2_q[1]);
      b3[2] = -opb_t'(q2_q[2]);
      b3[3] = opb_t'(q2_q[3]);
    end else begin
      b3[0] = '0;
      b3[1] = '0;
      b3[2] = '0;
      b3[3] = OneQ;
    end
  end

  qpr_mul u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v2),
    .a_i    (a3),
    .b_i    (b3),
    .vld_o  (v3),
    .prod_o (pr3)
  );

  qpr_rnd u_rnd_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v3),
    .prod_i (pr3),
    .vld_o  (v4),
    .rnd_o  (rn4)
  );

  qpr_sat u_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v4),
    .mode_i (m4_q),
    .rnd_i  (rn4),
    .vld_o  (valid_o),
    .r_o    (res),
    .ovf_o  (overflow_o)
  );

  assign r_x_o = res[0];
  assign r_y_o = res[1];
  assign r_z_o = res[2];
  assign r_w_o = res[3];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##5 valid_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, 5))
    else $error("result without an accepted word");

  a_rot_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4 && m4_q == ModeRotate) |=> (r_w_o == 16'sd0))
    else $error("rotate result has nonzero scalar");

  a_ovf_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && overflow_o) |->
      (r_x_o == 16'sh7fff || r_x_o == -16'sh8000 ||
       r_y_o == 16'sh7fff || r_y_o == -16'sh8000 ||
       r_z_o == 16'sh7fff || r_z_o == -16'sh8000 ||
       r_w_o == 16'sh7fff || r_w_o == -16'sh8000))
    else $error("overflow set without a clipped component");

endmodule

/* rtl/qpr_mul.sv */
module qpr_mul
  import qpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  opa4_t   a_i,
  input  opb4_t   b_i,
  output logic    vld_o,
  output prod16_t prod_o
);

  logic    vld_q;
  prod16_t prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // all sixteen cross products a[i]*b[j]
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_q[i*4+j] <= prod_t'(a_i[i]) * prod_t'(b_i[j]);
      end
    end
  end

  assign vld_o  = vld_q;
  assign prod_o = prod_q;

endmodule

/* rtl/qpr_rnd.sv */
module qpr_rnd
  import qpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  prod16_t prod_i,
  output logic    vld_o,
  output rnd4_t   rnd_o
);

  logic  vld_q;
  rnd4_t rnd_q;
  sum_t  pe [16];
  sum_t  sum [4];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pe[k] = sum_t'(prod_i[k]);
    end
    // Hamilton combination, element order x, y, z, w
    sum[0] = pe[1*4+2] - pe[2*4+1] + pe[0*4+3] + pe[3*4+0] + Half;
    sum[1] = pe[2*4+0] - pe[0*4+2] + pe[1*4+3] + pe[3*4+1] + Half;
    sum[2] = pe[0*4+1] - pe[1*4+0] + pe[2*4+3] + pe[3*4+2] + Half;
    sum[3] = pe[3*4+3] - pe[0*4+0] - pe[1*4+1] - pe[2*4+2] + Half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // floor after adding half: ties go up
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      rnd_q[c] <= sum[c][SumW-1:FracBits];
    end
  end

  assign vld_o = vld_q;
  assign rnd_o = rnd_q;

endmodule

/* rtl/qpr_sat.sv */
module qpr_sat
  import qpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic               mode_i,
  input  rnd4_t              rnd_i,
  output logic               vld_o,
  output logic signed [15:0] r_o [4],
  output logic               ovf_o
);

  logic               vld_q;
  logic signed [15:0] r_q [4];
  logic               ovf_q;
  logic signed [15:0] r_d [4];
  logic               ovf_d;
  logic [3:0]         clip;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      clip[c] = 1'b0;
      if (rnd_i[c] > SatHi) begin
        r_d[c]  = 16'sh7fff;
        clip[c] = 1'b1;
      end else if (rnd_i[c] < SatLo) begin
        r_d[c]  = -16'sh8000;
        clip[c] = 1'b1;
      end else begin
        r_d[c] = rnd_i[c][15:0];
      end
    end
    // drop the scalar in rotate mode and leave its clip out of the overflow flag
    if (mode_i == ModeRotate) begin
      r_d[3] = '0;
      ovf_d  = |clip[2:0];
    end else begin
      ovf_d  = |clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    ovf_q <= ovf_d;
  end

  assign vld_o = vld_q;
  assign r_o   = r_q;
  assign ovf_o = ovf_q;

endmodule
